// ===== hw/rtl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// shared types and constants of the png stored stream encoder
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

  localparam int unsigned MAX_WIDTH   = 8192;
  localparam int unsigned MAX_HEIGHT  = 8192;
  localparam int unsigned DIM_W       = 14;
  localparam int unsigned RAW_W       = 28;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] STORED_MAX = 16'hFFFF;
  localparam logic [16:0] ADLER_MOD  = 17'd65521;
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;

  // register indexes on the configuration port
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // back end geometry; the user keeps it stable with words in flight, unenforced
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [31:0]      idat_len;
  } img_cfg_t;

  // one accepted word, classified by the front end
  typedef struct packed {
    logic [7:0]  px;
    logic        start;
    logic        filt;
    logic        hdr1;
    logic        fin1;
    logic [15:0] len1;
    logic        hdr2;
    logic        fin2;
    logic [15:0] len2;
    logic        last;
  } desc_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pse_front.sv =====
// ----------------------------------------------------------------------------
// pse_front
// size registers, stream length and per-word classification
// ----------------------------------------------------------------------------
`default_nettype none

module pse_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [pse_pkg::DIM_W-1:0] cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [7:0]              in_pixel_byte,
  input  wire logic                    q_full,
  output logic                         q_push,
  output pse_pkg::desc_t               q_data,
  output pse_pkg::img_cfg_t            img_cfg
);

  localparam int unsigned DW = pse_pkg::DIM_W;
  localparam int unsigned RW = pse_pkg::RAW_W;

  logic [DW-1:0] width_r, height_r;
  logic [14:0]   row_bytes_r;
  logic [RW-1:0] raw_r;
  logic [12:0]   blocks_r;
  logic [31:0]   idat_len_r;
  logic [1:0]    settle_r;
  logic          phase_r, phase_nxt;
  logic [14:0]   col_r, col_nxt;
  logic [15:0]   blk_r, blk_nxt;
  logic [RW-1:0] rem_r, rem_nxt;

  logic [DW-1:0] cfg_v;
  logic [DW-1:0] cfg_lim;
  logic          accept;

  always_comb begin
    cfg_lim = (cfg_index == pse_pkg::REG_IMAGE_HEIGHT) ? DW'(pse_pkg::MAX_HEIGHT)
                                                       : DW'(pse_pkg::MAX_WIDTH);
    cfg_v = cfg_wdata;
    if (cfg_v == '0) begin
      cfg_v = DW'(1);
    end else if (cfg_v > cfg_lim) begin
      cfg_v = cfg_lim;
    end
  end

  // length pipeline: row bytes, raw size, block count, idat length
  logic [29:0] raw_full;
  logic [28:0] y;
  logic [12:0] qa;
  logic [16:0] qs;
  assign raw_full = 30'(height_r) * 30'({1'b0, row_bytes_r} + 16'd1);
  // ceil(raw / 65535) with y = hi*65536 + lo = hi*65535 + (hi + lo)
  assign y  = 29'(raw_r) + 29'd65534;
  assign qa = y[28:16];
  assign qs = 17'(qa) + 17'(y[15:0]);

  always_ff @(posedge clk) begin
    row_bytes_r <= 15'(width_r) * 15'd3;
    raw_r       <= raw_full[RW-1:0];
    blocks_r    <= qa + ((qs >= 17'(pse_pkg::STORED_MAX)) ? 13'd1 : 13'd0);
    idat_len_r  <= 32'd6 + {17'd0, blocks_r, 2'b00} + 32'(blocks_r) + 32'(raw_r);
  end

  assign in_stall = q_full || (settle_r != 2'd0);
  assign accept   = in_valid && !in_stall;

  // classification of one word
  logic [RW-1:0] rem0, rem1;
  logic [15:0]   blk0, blk1, blk2;
  logic [14:0]   col0, col1;
  pse_pkg::desc_t d;

  always_comb begin
    d       = '0;
    d.px    = in_pixel_byte;
    d.start = !phase_r;
    rem0    = d.start ? raw_r : rem_r;
    blk0    = d.start ? 16'd0 : blk_r;
    col0    = d.start ? 15'd0 : col_r;
    d.filt  = (col0 == 15'd0);
    rem1    = rem0;
    blk1    = blk0;
    if (d.filt) begin
      d.hdr1 = (blk0 == 16'd0);
      d.fin1 = (rem0 <= RW'(pse_pkg::STORED_MAX));
      d.len1 = d.fin1 ? rem0[15:0] : pse_pkg::STORED_MAX;
      if (d.hdr1) begin
        blk1 = d.len1;
      end
      if (blk1 != 16'd0) begin
        blk1 = blk1 - 16'd1;
      end
      if (rem1 != '0) begin
        rem1 = rem1 - RW'(1);
      end
    end
    d.hdr2 = (blk1 == 16'd0);
    d.fin2 = (rem1 <= RW'(pse_pkg::STORED_MAX));
    d.len2 = d.fin2 ? rem1[15:0] : pse_pkg::STORED_MAX;
    blk2   = d.hdr2 ? d.len2 : blk1;
    if (blk2 != 16'd0) begin
      blk2 = blk2 - 16'd1;
    end
    rem_nxt = rem1;
    if (rem_nxt != '0) begin
      rem_nxt = rem_nxt - RW'(1);
    end
    blk_nxt   = blk2;
    col1      = col0 + 15'd1;
    col_nxt   = (col1 >= row_bytes_r) ? 15'd0 : col1;
    d.last    = (rem_nxt == '0);
    phase_nxt = !d.last;
  end

  assign q_push = accept;
  assign q_data = d;
  assign img_cfg.width    = width_r;
  assign img_cfg.height   = height_r;
  assign img_cfg.idat_len = idat_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DW'(64);
      height_r <= DW'(64);
      settle_r <= 2'd3;
      phase_r  <= 1'b0;
    end else begin
      if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
      if (accept) begin
        phase_r <= phase_nxt;
      end
      if (cfg_we) begin
        // new size abandons the current image
        phase_r  <= 1'b0;
        settle_r <= 2'd3;
        unique case (cfg_index)
          pse_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_v;
          pse_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_v;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_r <= col_nxt;
      blk_r <= blk_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pse_queue.sv =====
// ----------------------------------------------------------------------------
// pse_queue
// short word queue between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

module pse_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  pse_pkg::desc_t      push_data,
  input  wire logic           pop,
  output pse_pkg::desc_t      head,
  output logic                empty,
  output logic                full
);

  localparam int unsigned PW = pse_pkg::QPTR_W;

  pse_pkg::desc_t mem_r [pse_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [PW:0]    cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (PW+1)'(pse_pkg::QUEUE_DEPTH));
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (PW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (PW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pse_back.sv =====
// ----------------------------------------------------------------------------
// pse_back
// byte sequencer: file header, block headers, data, trailer, crc and adler
// ----------------------------------------------------------------------------
`default_nettype none

module pse_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  pse_pkg::desc_t     d,
  input  wire logic          q_empty,
  output logic               q_pop,
  input  pse_pkg::img_cfg_t  img_cfg,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_out_byte,
  output logic               out_run_last,
  output logic               out_file_end
);

  typedef enum logic [5:0] {
    SEG_HEAD = 6'b000001,
    SEG_HDR1 = 6'b000010,
    SEG_FILT = 6'b000100,
    SEG_HDR2 = 6'b001000,
    SEG_PIX  = 6'b010000,
    SEG_TAIL = 6'b100000
  } seg_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (pse_pkg::CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  seg_t        seg_r;
  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] snap_r;
  logic [15:0] alo_r, ahi_r;
  logic        ov_r, rl_r, fe_r;
  logic [7:0]  ob_r;

  seg_t        seg, seg_nx;
  logic [5:0]  cnt, seg_len;
  logic [7:0]  b;
  logic        crc_init, take_snap, done, ld, raw_b;
  logic [31:0] crc_out;
  logic        fin;
  logic [15:0] len;

  assign ld = !q_empty && (!ov_r || !out_stall);

  always_comb begin
    if (busy_r) begin
      seg = seg_r;
      cnt = cnt_r;
    end else begin
      cnt = 6'd0;
      priority if (d.start)            seg = SEG_HEAD;
      else if (d.filt && d.hdr1)       seg = SEG_HDR1;
      else if (d.filt)                 seg = SEG_FILT;
      else if (d.hdr2)                 seg = SEG_HDR2;
      else                             seg = SEG_PIX;
    end
  end

  always_comb begin
    b         = 8'h00;
    crc_init  = 1'b0;
    take_snap = 1'b0;
    raw_b     = 1'b0;
    seg_len   = 6'd1;
    seg_nx    = SEG_PIX;
    done      = 1'b0;
    fin       = (seg == SEG_HDR1) ? d.fin1 : d.fin2;
    len       = (seg == SEG_HDR1) ? d.len1 : d.len2;
    crc_out   = (cnt == 6'd29 || cnt == 6'd4 || cnt == 6'd16) ? ~crc_r : snap_r;
    unique case (seg)
      SEG_HEAD: begin
        seg_len = 6'd43;
        priority if (d.filt && d.hdr1) seg_nx = SEG_HDR1;
        else if (d.filt)               seg_nx = SEG_FILT;
        else if (d.hdr2)               seg_nx = SEG_HDR2;
        else                           seg_nx = SEG_PIX;
        crc_init  = (cnt == 6'd12) || (cnt == 6'd37);
        take_snap = (cnt == 6'd29);
        unique case (cnt)
          6'd0:  b = 8'h89;
          6'd1:  b = 8'h50;
          6'd2:  b = 8'h4E;
          6'd3:  b = 8'h47;
          6'd4:  b = 8'h0D;
          6'd5:  b = 8'h0A;
          6'd6:  b = 8'h1A;
          6'd7:  b = 8'h0A;
          6'd11: b = 8'd13;
          6'd12: b = 8'h49;
          6'd13: b = 8'h48;
          6'd14: b = 8'h44;
          6'd15: b = 8'h52;
          6'd18: b = {2'b00, img_cfg.width[13:8]};
          6'd19: b = img_cfg.width[7:0];
          6'd22: b = {2'b00, img_cfg.height[13:8]};
          6'd23: b = img_cfg.height[7:0];
          6'd24: b = 8'd8;
          6'd25: b = 8'd2;
          6'd29: b = crc_out[31:24];
          6'd30: b = crc_out[23:16];
          6'd31: b = crc_out[15:8];
          6'd32: b = crc_out[7:0];
          6'd33: b = img_cfg.idat_len[31:24];
          6'd34: b = img_cfg.idat_len[23:16];
          6'd35: b = img_cfg.idat_len[15:8];
          6'd36: b = img_cfg.idat_len[7:0];
          6'd37: b = 8'h49;
          6'd38: b = 8'h44;
          6'd39: b = 8'h41;
          6'd40: b = 8'h54;
          6'd41: b = 8'h78;
          6'd42: b = 8'h01;
          default: b = 8'h00;
        endcase
      end
      SEG_HDR1, SEG_HDR2: begin
        seg_len = 6'd5;
        seg_nx  = (seg == SEG_HDR1) ? SEG_FILT : SEG_PIX;
        unique case (cnt)
          6'd0:    b = {7'd0, fin};
          6'd1:    b = len[7:0];
          6'd2:    b = len[15:8];
          6'd3:    b = ~len[7:0];
          default: b = ~len[15:8];
        endcase
      end
      SEG_FILT: begin
        raw_b  = 1'b1;
        seg_nx = d.hdr2 ? SEG_HDR2 : SEG_PIX;
      end
      SEG_PIX: begin
        raw_b  = 1'b1;
        b      = d.px;
        seg_nx = SEG_TAIL;
        done   = !d.last;
      end
      SEG_TAIL: begin
        seg_len   = 6'd20;
        done      = 1'b1;
        crc_init  = (cnt == 6'd12);
        take_snap = (cnt == 6'd4) || (cnt == 6'd16);
        unique case (cnt)
          6'd0:  b = ahi_r[15:8];
          6'd1:  b = ahi_r[7:0];
          6'd2:  b = alo_r[15:8];
          6'd3:  b = alo_r[7:0];
          6'd4, 6'd16: b = crc_out[31:24];
          6'd5, 6'd17: b = crc_out[23:16];
          6'd6, 6'd18: b = crc_out[15:8];
          6'd7, 6'd19: b = crc_out[7:0];
          6'd12: b = 8'h49;
          6'd13: b = 8'h45;
          6'd14: b = 8'h4E;
          6'd15: b = 8'h44;
          default: b = 8'h00;
        endcase
      end
    endcase
    crc_nxt = crc_byte(crc_init ? 32'hFFFFFFFF : crc_r, b);
  end

  logic seg_end;
  assign seg_end = (cnt == seg_len - 6'd1);
  assign q_pop   = ld && seg_end && done;

  // adler-32 over filter and pixel bytes
  logic [16:0] lo_s, hi_s;
  logic [15:0] lo_n, hi_n;
  always_comb begin
    lo_s = 17'(alo_r) + 17'(b);
    lo_n = (lo_s >= pse_pkg::ADLER_MOD) ? 16'(lo_s - pse_pkg::ADLER_MOD) : lo_s[15:0];
    hi_s = 17'(ahi_r) + 17'(lo_n);
    hi_n = (hi_s >= pse_pkg::ADLER_MOD) ? 16'(hi_s - pse_pkg::ADLER_MOD) : hi_s[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      crc_r  <= 32'hFFFFFFFF;
      alo_r  <= 16'd1;
      ahi_r  <= 16'd0;
    end else begin
      if (ov_r && !out_stall) begin
        ov_r <= 1'b0;
      end
      if (ld) begin
        ov_r  <= 1'b1;
        crc_r <= crc_nxt;
        if (seg == SEG_HEAD && cnt == 6'd0) begin
          alo_r <= 16'd1;
          ahi_r <= 16'd0;
        end else if (raw_b) begin
          alo_r <= lo_n;
          ahi_r <= hi_n;
        end
        if (seg_end) begin
          busy_r <= !done;
          seg_r  <= seg_nx;
          cnt_r  <= 6'd0;
        end else begin
          busy_r <= 1'b1;
          seg_r  <= seg;
          cnt_r  <= cnt + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      ob_r <= b;
      rl_r <= seg_end && done;
      fe_r <= seg_end && (seg == SEG_TAIL);
      if (take_snap) begin
        snap_r <= ~crc_r;
      end
    end
  end

  assign out_valid    = ov_r;
  assign out_out_byte = ob_r;
  assign out_run_last = rl_r;
  assign out_file_end = fe_r;

endmodule

`default_nettype wire

// ===== hw/rtl/png_stored_stream_encoder_top.sv =====
// ----------------------------------------------------------------------------
// png_stored_stream_encoder_top
// streaming png encoder for rgb8 images using stored deflate blocks
// ----------------------------------------------------------------------------
// in_*: raw rgb bytes in raster order, one word per accepted cycle.
// out_*: the png file byte by byte; out_run_last marks the last byte caused
//   by an input word, out_file_end the last byte of the file.
// cfg_*: image_width (index 0) and image_height (index 1); a write restarts
//   the file and holds in_stall while the stream length pipeline settles.
// the front end classifies each word into a four-entry queue; the back end
// emits one output byte per cycle unless the output stalls or the queue is
// empty; an input word yields one byte plus one for each filter byte and
// five for each block header; the first word of a file adds 43 header bytes
// and the last a 20 byte trailer. an accepted word goes into the queue,
// then its first byte into the back end output register. a stalled output
// holds its byte while the queue takes words until it is full. after reset
// sizes are 64 x 64 and in_stall is high while the length pipeline settles.
// ----------------------------------------------------------------------------
`default_nettype none

module png_stored_stream_encoder_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [pse_pkg::DIM_W-1:0]  cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 in_pixel_byte,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [7:0]                      out_out_byte,
  output logic                            out_run_last,
  output logic                            out_file_end
);

  pse_pkg::desc_t    push_data, head;
  pse_pkg::img_cfg_t img_cfg;
  logic              push, pop, empty, full;

  pse_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_pixel_byte,
    .q_full(full), .q_push(push), .q_data(push_data), .img_cfg(img_cfg)
  );

  pse_queue u_queue (
    .clk, .rst_n, .push(push), .push_data(push_data), .pop(pop),
    .head(head), .empty(empty), .full(full)
  );

  pse_back u_back (
    .clk, .rst_n, .d(head), .q_empty(empty), .q_pop(pop), .img_cfg(img_cfg),
    .out_valid, .out_stall, .out_out_byte, .out_run_last, .out_file_end
  );

endmodule

`default_nettype wire

// ===== hw/rtl/pse_checker.sv =====
// ----------------------------------------------------------------------------
// pse_checker
// port level checks of the png stored stream encoder
// ----------------------------------------------------------------------------
`default_nettype none

module pse_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       cfg_we,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_out_byte,
  input wire logic       out_run_last,
  input wire logic       out_file_end
);

  // file end is always the last byte of its word
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_file_end |-> out_run_last)
    else $error("file end without run last");

  // iend crc is fixed, its last byte is 0x82
  a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_file_end |-> out_out_byte == 8'h82)
    else $error("wrong final byte");

  // size write holds off input while the length settles
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input taken right after size write");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_out_byte))
    else $error("stalled output changed");

endmodule

bind png_stored_stream_encoder_top pse_checker u_pse_checker (
  .clk, .rst_n, .cfg_we, .in_stall, .out_valid, .out_stall,
  .out_out_byte, .out_run_last, .out_file_end
);

`default_nettype wire
